/* src/group_by_order_accumulate_unit_defines.svh */
// assertion macros for the group-by order accumulate unit
`ifndef GROUP_BY_ORDER_ACCUMULATE_UNIT_DEFINES_SVH
`define GROUP_BY_ORDER_ACCUMULATE_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define GBOA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gboa check failed");

// next-cycle implication, clocked on clk_i, off during reset
`define GBOA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gboa check failed");

`endif

/* src/gboa_pkg.sv */
// shared types and widths of the group-by order accumulate unit
package gboa_pkg;

  localparam int unsigned CodeW   = 31;
  localparam int unsigned DateW   = 27;
  localparam int unsigned BranchW = 16;
  localparam int unsigned QtyW    = 16;
  localparam int unsigned PriceW  = 24;
  localparam int unsigned ProdW   = QtyW + PriceW;
  localparam int unsigned QsumW   = 32;
  localparam int unsigned VsumW   = 48;

  typedef struct packed {
    logic [CodeW-1:0]   code;
    logic [DateW-1:0]   date;
    logic [BranchW-1:0] branch;
    logic [QtyW-1:0]    qty;
    logic [ProdW-1:0]   prod;
  } item_t;

  typedef struct packed {
    logic               valid;
    logic [CodeW-1:0]   code;
    logic [DateW-1:0]   date;
    logic [BranchW-1:0] branch;
    logic [QsumW-1:0]   qsum;
    logic [VsumW-1:0]   vsum;
  } entry_t;

  typedef struct packed {
    logic fold;
    logic shift;
  } cell_ctrl_t;

endpackage

/* src/gboa_cell.sv */
// one table cell: holds an entry, matches and accumulates, shifts toward the head
module gboa_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gboa_pkg::cell_ctrl_t ctrl_i,
  input  logic                alloc_i,
  input  gboa_pkg::item_t     item_i,
  input  gboa_pkg::entry_t    next_i,
  output gboa_pkg::entry_t    entry_o,
  output logic                match_o
);

  logic                         valid_q;
  logic [gboa_pkg::CodeW-1:0]   code_q;
  logic [gboa_pkg::DateW-1:0]   date_q;
  logic [gboa_pkg::BranchW-1:0] branch_q;
  logic [gboa_pkg::QsumW-1:0]   qsum_q;
  logic [gboa_pkg::VsumW-1:0]   vsum_q;
  logic [gboa_pkg::QsumW:0] qsum_add;
  logic [gboa_pkg::VsumW:0] vsum_add;
  logic [gboa_pkg::QsumW-1:0] qsum_sat;
  logic [gboa_pkg::VsumW-1:0] vsum_sat;

  assign match_o = valid_q && (code_q == item_i.code);
  assign entry_o = '{valid: valid_q, code: code_q, date: date_q, branch: branch_q,
                     qsum: qsum_q, vsum: vsum_q};

  always_comb begin
    qsum_add = {1'b0, qsum_q} +
               {{(gboa_pkg::QsumW + 1 - gboa_pkg::QtyW){1'b0}}, item_i.qty};
    vsum_add = {1'b0, vsum_q} +
               {{(gboa_pkg::VsumW + 1 - gboa_pkg::ProdW){1'b0}}, item_i.prod};
    qsum_sat = qsum_add[gboa_pkg::QsumW] ? '1 : qsum_add[gboa_pkg::QsumW-1:0];
    vsum_sat = vsum_add[gboa_pkg::VsumW] ? '1 : vsum_add[gboa_pkg::VsumW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= next_i.valid;
    end else if (ctrl_i.fold && alloc_i) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      code_q   <= next_i.code;
      date_q   <= next_i.date;
      branch_q <= next_i.branch;
      qsum_q   <= next_i.qsum;
      vsum_q   <= next_i.vsum;
    end else if (ctrl_i.fold && alloc_i) begin
      code_q   <= item_i.code;
      date_q   <= item_i.date;
      branch_q <= item_i.branch;
      qsum_q   <= {{(gboa_pkg::QsumW - gboa_pkg::QtyW){1'b0}}, item_i.qty};
      vsum_q   <= {{(gboa_pkg::VsumW - gboa_pkg::ProdW){1'b0}}, item_i.prod};
    end else if (ctrl_i.fold && match_o) begin
      qsum_q <= qsum_sat;
      vsum_q <= vsum_sat;
    end
  end

endmodule

/* src/group_by_order_accumulate_unit.sv */
// Group-by order accumulate unit. An accepted item is registered together
// with quantity times price and then folded into a row of TABLE_DEPTH cells
// that all compare the order code at once and either add to the matching
// entry (sums saturate), open the next free one, or, when the table is full,
// drop the item and set the overflow flag. busy is high during that fold. An
// item with last_item set is folded first, then the row shifts toward cell 0
// once a cycle and each table entry appears on the result ports for one cycle
// with valid_o, in the order first seen; last_entry_o marks the final one and
// the table and overflow flag are then empty again. busy is already low during
// that final strobe. Results cannot be held off by the receiver.
module group_by_order_accumulate_unit #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [30:0] order_code_i,
  input  logic [26:0] order_date_i,
  input  logic [15:0] branch_code_i,
  input  logic [15:0] quantity_i,
  input  logic [23:0] unit_price_i,
  input  logic        last_item_i,
  output logic        valid_o,
  output logic [30:0] out_order_code_o,
  output logic [26:0] out_order_date_o,
  output logic [15:0] out_branch_code_o,
  output logic [31:0] total_quantity_o,
  output logic [47:0] total_value_o,
  output logic        overflow_o,
  output logic        last_entry_o
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FOLD,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   count_q;
  logic              ovf_q;
  logic              last_q;
  gboa_pkg::item_t   item_q;
  gboa_pkg::cell_ctrl_t ctrl;
  gboa_pkg::entry_t  chain [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] match;
  logic [TABLE_DEPTH-1:0] alloc;
  logic              hit;
  logic              full;
  logic              accept;

  assign accept     = start && (state_q == ST_IDLE);
  assign busy       = (state_q != ST_IDLE);
  assign hit        = |match;
  assign full       = (count_q == CntW'(TABLE_DEPTH));
  assign ctrl.fold  = (state_q == ST_FOLD);
  assign ctrl.shift = (state_q == ST_EMIT);
  assign chain[TABLE_DEPTH] = '0;

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    assign alloc[k] = !hit && (count_q == CntW'(k));
    gboa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .alloc_i (alloc[k]),
      .item_i  (item_q),
      .next_i  (chain[k+1]),
      .entry_o (chain[k]),
      .match_o (match[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.code   <= order_code_i;
      item_q.date   <= order_date_i;
      item_q.branch <= branch_code_i;
      item_q.qty    <= quantity_i;
      item_q.prod   <= {{gboa_pkg::PriceW{1'b0}}, quantity_i} *
                       {{gboa_pkg::QtyW{1'b0}}, unit_price_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      count_q           <= '0;
      ovf_q             <= 1'b0;
      last_q            <= 1'b0;
      valid_o           <= 1'b0;
      out_order_code_o  <= '0;
      out_order_date_o  <= '0;
      out_branch_code_o <= '0;
      total_quantity_o  <= '0;
      total_value_o     <= '0;
      overflow_o        <= 1'b0;
      last_entry_o      <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            last_q  <= last_item_i;
            state_q <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          if (!hit && !full) begin
            count_q <= count_q + CntW'(1);
          end
          if (!hit && full) begin
            ovf_q <= 1'b1;
          end
          state_q <= last_q ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          valid_o           <= 1'b1;
          out_order_code_o  <= chain[0].code;
          out_order_date_o  <= chain[0].date;
          out_branch_code_o <= chain[0].branch;
          total_quantity_o  <= chain[0].qsum;
          total_value_o     <= chain[0].vsum;
          overflow_o        <= ovf_q;
          last_entry_o      <= (count_q == CntW'(1));
          count_q           <= count_q - CntW'(1);
          if (count_q == CntW'(1)) begin
            ovf_q   <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/gboa_checker.sv */
// port-level checks of the group-by order accumulate unit and their bind
`include "group_by_order_accumulate_unit_defines.svh"

module gboa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        valid_o,
  input logic        overflow_o,
  input logic        last_entry_o
);

  // an accepted item is always folded in the following cycle
  `GBOA_ASSERT_NEXT(a_fold_after_accept, start && !busy, busy && !valid_o)
  // mid-batch results keep the unit busy
  `GBOA_ASSERT_SAME(a_busy_mid_batch, valid_o && !last_entry_o, busy)
  // a batch is emitted without gaps
  `GBOA_ASSERT_NEXT(a_batch_contiguous, valid_o && !last_entry_o, valid_o)
  // overflow is the same on every result of a batch
  `GBOA_ASSERT_NEXT(a_overflow_steady, valid_o && !last_entry_o, overflow_o == $past(overflow_o))
  // the final entry ends the batch
  `GBOA_ASSERT_NEXT(a_batch_ends, valid_o && last_entry_o, !valid_o)

endmodule

bind group_by_order_accumulate_unit gboa_checker u_gboa_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .valid_o           (valid_o),
  .overflow_o        (overflow_o),
  .last_entry_o      (last_entry_o)
);
